>>> rtl/hsbp_pkg.sv
// Shared types and constants for the Huffman symbol bit packer.
// No dependencies; every other file of the block but hsbp_ram refers to this package.
`timescale 1ns / 1ps

package hsbp_pkg;

   localparam int SYM_W  = 8;   // symbol field width
   localparam int PAT_W  = 32;  // code or literal pattern width
   localparam int LEN_W  = 6;   // bit count width, holds 0..32
   localparam int MODE_W = 2;
   localparam int BYTE_W = 8;
   localparam int FILL_W = 3;   // bits held in the open byte, 0..7

   typedef enum logic [MODE_W-1:0] {
      MODE_LOAD    = 2'd0,
      MODE_ENCODE  = 2'd1,
      MODE_LITERAL = 2'd2,
      MODE_FLUSH   = 2'd3
   } mode_type;

   // One unit of packing work handed from the front end to the packer.
   typedef struct packed {
      logic             flush;
      logic [PAT_W-1:0] pattern;
      logic [LEN_W-1:0] len;
   } job_type;

endpackage

>>> rtl/hsbp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module hsbp_ram #(
   parameter int WIDTH = 38,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/hsbp_front.sv
// Front end: accepts requests, maintains the code table and turns each
// request into a packing job. Depends on hsbp_pkg and hsbp_ram.
`timescale 1ns / 1ps

module hsbp_front #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [hsbp_pkg::MODE_W-1:0]    req_mode,
   input  logic [hsbp_pkg::SYM_W-1:0]     req_symbol,
   input  logic [hsbp_pkg::PAT_W-1:0]     req_bit_pattern,
   input  logic [hsbp_pkg::LEN_W-1:0]     req_bit_count,
   output logic                           push_valid,
   input  logic                           push_ready,
   output hsbp_pkg::job_type              push_job
);

   localparam int LEN_W     = hsbp_pkg::LEN_W;
   localparam int PAT_W     = hsbp_pkg::PAT_W;
   localparam int SYM_W     = hsbp_pkg::SYM_W;
   localparam int ADDR_W    = $clog2(SYMBOL_COUNT);
   localparam int ENTRY_W   = PAT_W + LEN_W;
   localparam int LIMIT_INT = (MAX_CODE_LEN < PAT_W) ? MAX_CODE_LEN : PAT_W;
   localparam logic [LEN_W-1:0] LEN_LIMIT = LEN_W'(LIMIT_INT);

   logic                    accept;
   logic                    in_range;
   logic [ADDR_W-1:0]       addr;
   logic [LEN_W-1:0]        clamped_len;

   logic                    wr_en;
   logic                    rd_en;
   logic [ENTRY_W-1:0]      rd_data;

   logic [SYMBOL_COUNT-1:0] loaded_ff, loaded_in;
   logic                    s1_valid_ff, s1_valid_in;
   logic                    s1_lookup_ff, s1_lookup_in;
   logic                    s1_hit_ff, s1_hit_in;
   hsbp_pkg::job_type       s1_job_ff, s1_job_in;
   logic                    s1_done;

   assign addr        = req_symbol[ADDR_W-1:0];
   assign in_range    = ({1'b0, req_symbol} < (SYM_W + 1)'(SYMBOL_COUNT));
   assign clamped_len = (req_bit_count > LEN_LIMIT) ? LEN_LIMIT : req_bit_count;

   hsbp_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (SYMBOL_COUNT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (addr),
      .wr_data ({clamped_len, req_bit_pattern}),
      .rd_en   (rd_en),
      .rd_addr (addr),
      .rd_data (rd_data)
   );

   // Stage output: a lookup takes its pattern and length from the table read.
   always_comb begin
      if (s1_lookup_ff) begin
         push_job.flush   = 1'b0;
         push_job.pattern = rd_data[PAT_W-1:0];
         push_job.len     = s1_hit_ff ? rd_data[ENTRY_W-1:PAT_W] : '0;
      end else begin
         push_job = s1_job_ff;
      end
   end

   // Zero-length codes are dropped here; they would emit nothing.
   assign push_valid = s1_valid_ff && (!s1_lookup_ff || (push_job.len != '0));
   assign s1_done    = s1_valid_ff && (!push_valid || push_ready);
   assign req_ready  = !s1_valid_ff || s1_done;
   assign accept     = req_valid && req_ready;

   always_comb begin
      wr_en        = 1'b0;
      rd_en        = 1'b0;
      loaded_in    = loaded_ff;
      s1_valid_in  = s1_valid_ff && !s1_done;
      s1_lookup_in = s1_lookup_ff;
      s1_hit_in    = s1_hit_ff;
      s1_job_in    = s1_job_ff;
      if (accept) begin
         case (hsbp_pkg::mode_type'(req_mode))
            hsbp_pkg::MODE_LOAD: begin
               if (in_range) begin
                  wr_en           = 1'b1;
                  loaded_in[addr] = 1'b1;
               end
            end
            hsbp_pkg::MODE_ENCODE: begin
               rd_en        = 1'b1;
               s1_valid_in  = 1'b1;
               s1_lookup_in = 1'b1;
               s1_hit_in    = in_range && loaded_ff[addr];
            end
            hsbp_pkg::MODE_LITERAL: begin
               s1_valid_in       = (clamped_len != '0);
               s1_lookup_in      = 1'b0;
               s1_job_in.flush   = 1'b0;
               s1_job_in.pattern = req_bit_pattern;
               s1_job_in.len     = clamped_len;
            end
            hsbp_pkg::MODE_FLUSH: begin
               s1_valid_in       = 1'b1;
               s1_lookup_in      = 1'b0;
               s1_job_in.flush   = 1'b1;
               s1_job_in.pattern = '0;
               s1_job_in.len     = '0;
            end
            default: begin
               s1_valid_in = s1_valid_ff && !s1_done;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loaded_ff   <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         loaded_ff   <= loaded_in;
         s1_valid_ff <= s1_valid_in;
      end
      s1_lookup_ff <= s1_lookup_in;
      s1_hit_ff    <= s1_hit_in;
      s1_job_ff    <= s1_job_in;
   end

endmodule

>>> rtl/hsbp_queue.sv
// Small FIFO of packing jobs between the front end and the packer.
// Depends on hsbp_pkg for the job type.
`timescale 1ns / 1ps

module hsbp_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  hsbp_pkg::job_type push_job,
   output logic              pop_valid,
   input  logic              pop_ready,
   output hsbp_pkg::job_type pop_job
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hsbp_pkg::job_type slots_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = slots_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> rtl/hsbp_back.sv
// Packer: takes jobs from the queue, packs their bits LSB first into bytes
// and drives the registered response channel. Depends on hsbp_pkg.
`timescale 1ns / 1ps

module hsbp_back (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop_ready,
   input  hsbp_pkg::job_type             pop_job,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hsbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last_of_run
);

   localparam int PAT_W  = hsbp_pkg::PAT_W;
   localparam int LEN_W  = hsbp_pkg::LEN_W;
   localparam int BYTE_W = hsbp_pkg::BYTE_W;
   localparam int FILL_W = hsbp_pkg::FILL_W;
   localparam int TAKE_W = FILL_W + 1;   // 0..8 bits per step

   logic [PAT_W-1:0]  pat_ff, pat_in;
   logic [LEN_W-1:0]  rem_ff, rem_in;
   logic [FILL_W-1:0] fill_ff, fill_in;
   logic [BYTE_W-2:0] partial_ff, partial_in;
   logic              out_valid_ff, out_valid_in;
   logic [BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic              out_last_ff, out_last_in;

   logic              idle;
   logic              out_free;
   logic [TAKE_W-1:0] space;
   logic [TAKE_W-1:0] take;
   logic [BYTE_W:0]   take_one;
   logic [BYTE_W-1:0] take_mask;
   logic [BYTE_W-1:0] new_bits;
   logic [BYTE_W-1:0] merged;
   logic [TAKE_W-1:0] new_fill;
   logic [LEN_W-1:0]  rem_next;
   logic              full;
   logic              step;

   assign idle      = (rem_ff == '0);
   assign pop_ready = idle;
   assign out_free  = !out_valid_ff || rsp_ready;

   always_comb begin
      space     = TAKE_W'(BYTE_W) - {1'b0, fill_ff};
      take      = (rem_ff < {{(LEN_W - TAKE_W){1'b0}}, space}) ? rem_ff[TAKE_W-1:0] : space;
      take_one  = (BYTE_W + 1)'(1) << take;
      take_mask = BYTE_W'(take_one - 1'b1);
      new_bits  = pat_ff[BYTE_W-1:0] & take_mask;
      merged    = {1'b0, partial_ff} | (new_bits << fill_ff);
      new_fill  = {1'b0, fill_ff} + take;
      rem_next  = rem_ff - {{(LEN_W - TAKE_W){1'b0}}, take};
      full      = (new_fill == TAKE_W'(BYTE_W));
      step      = !idle && (!full || out_free);
   end

   always_comb begin
      pat_in       = pat_ff;
      rem_in       = rem_ff;
      fill_in      = fill_ff;
      partial_in   = partial_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_byte_in  = out_byte_ff;
      out_last_in  = out_last_ff;
      if (idle && pop_valid) begin
         pat_in = pop_job.pattern;
         if (pop_job.flush) begin
            // Pad the open byte with zeros; nothing to do on a byte boundary.
            rem_in = (fill_ff == '0) ? '0 : LEN_W'(TAKE_W'(BYTE_W) - {1'b0, fill_ff});
         end else begin
            rem_in = pop_job.len;
         end
      end else if (step) begin
         pat_in = pat_ff >> take;
         rem_in = rem_next;
         if (full) begin
            out_valid_in = 1'b1;
            out_byte_in  = merged;
            // Another byte follows only if a whole byte of bits remains.
            out_last_in  = (rem_next < LEN_W'(BYTE_W));
            partial_in   = '0;
            fill_in      = '0;
         end else begin
            partial_in = merged[BYTE_W-2:0];
            fill_in    = new_fill[FILL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff       <= '0;
         fill_ff      <= '0;
         partial_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         rem_ff       <= rem_in;
         fill_ff      <= fill_in;
         partial_ff   <= partial_in;
         out_valid_ff <= out_valid_in;
      end
      pat_ff      <= pat_in;
      out_byte_ff <= out_byte_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule

>>> rtl/huffman_symbol_bit_packer.sv
// Huffman symbol encoder with a loaded code table and an LSB-first bit packer.
// Path: a request's bytes pass the front-end stage register, the queue slot,
// the packer's job registers and finally the response register.
// Packing: the packer takes a job only while idle and then merges the job's bits
// piece by piece into the open byte, so a new job waits until the last is through;
// a held response stalls the packer once a byte is complete.
// Reset (synchronous, active high) clears all table lengths at once through
// per-entry valid bits, empties the queue and clears the open byte.
`timescale 1ns / 1ps

module huffman_symbol_bit_packer #(
   parameter int MAX_CODE_LEN = 32,
   parameter int SYMBOL_COUNT = 256
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [hsbp_pkg::MODE_W-1:0]   req_mode,
   input  logic [hsbp_pkg::SYM_W-1:0]    req_symbol,
   input  logic [hsbp_pkg::PAT_W-1:0]    req_bit_pattern,
   input  logic [hsbp_pkg::LEN_W-1:0]    req_bit_count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [hsbp_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                          rsp_last_of_run
);

   // The front end handles table loads itself and turns encode, literal and
   // flush requests into jobs. The table RAM has registered read data,
   // so the front end holds one job in a stage register while it reads.
   logic              push_valid;
   logic              push_ready;
   hsbp_pkg::job_type push_job;

   // Queue side toward the packer.
   logic              pop_valid;
   logic              pop_ready;
   hsbp_pkg::job_type pop_job;

   hsbp_front #(
      .MAX_CODE_LEN (MAX_CODE_LEN),
      .SYMBOL_COUNT (SYMBOL_COUNT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_symbol      (req_symbol),
      .req_bit_pattern (req_bit_pattern),
      .req_bit_count   (req_bit_count),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_job        (push_job)
   );

   // The queue lets the front end keep taking requests while the packer is
   // busy emitting the bytes of a long code.
   hsbp_queue #(
      .DEPTH (2)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_job   (push_job),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_job    (pop_job)
   );

   // The packer merges up to a byte of bits per cycle into the open byte unless
   // a full byte waits on a held response, and registers each completed byte.
   hsbp_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_job         (pop_job),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule
